// ===== rtl/pcx_rle_pixel_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// PCX RLE pixel decoder assertion macros
// Shared concurrent assertion forms, clocked on the rising edge and disabled
// during reset.
// ----------------------------------------------------------------------------
`ifndef PCX_RLE_PIXEL_DECODER_MACROS_SVH
`define PCX_RLE_PIXEL_DECODER_MACROS_SVH

// Same-cycle implication
`define PCX_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcx assertion failed: same-cycle implication");

// Next-cycle implication
`define PCX_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcx assertion failed: next-cycle implication");

`endif

// ===== rtl/pcx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCX decoder package
// Widths, codes and the command/status structs shared by the decoder modules.
// ----------------------------------------------------------------------------
package pcx_pkg;

  // Default coordinate width
  localparam int COORD_BITS_DEF = 10;

  // Fixed field widths
  localparam int CFG_BITS     = 10;
  localparam int CFG_IDX_BITS = 2;
  localparam int BYTE_BITS    = 8;
  localparam int COUNT_BITS   = 6;

  // Run header detection
  localparam logic [BYTE_BITS-1:0] RUN_MASK = 8'hC0;

  // Register reset values
  localparam logic [CFG_BITS-1:0] LINE_BYTES_RST = 10'd320;

  // Register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_START_X    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_START_Y    = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_BYTES = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;     // take the input word
    logic load_hdr;   // latch a run header
    logic emit_lit;   // write one literal pixel
    logic start_run;  // take the run colour and write its first pixel
    logic drop_run;   // zero-count run: clear header, no write
    logic emit_run;   // write the next pixel of a run
  } pcx_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic out_free;   // output register can take a pixel this cycle
    logic awaiting;   // this word is a run colour
    logic header;     // this word is a run header
    logic cnt_zero;   // pending run count is zero
    logic cnt_one;    // pending run count is one
    logic rem_last;   // next run pixel is the last one
  } pcx_status_t;

endpackage
`default_nettype wire

// ===== rtl/pcx_byte_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCX compressed byte channel
// Valid/ready channel that carries one compressed byte and a frame start flag.
// ----------------------------------------------------------------------------
interface pcx_byte_if
  import pcx_pkg::*;
();

  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] data_byte;
  logic                 frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);

endinterface
`default_nettype wire

// ===== rtl/pcx_pixel_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCX pixel write channel
// Valid/ready channel that carries one pixel write with its coordinates.
// ----------------------------------------------------------------------------
interface pcx_pixel_if
  import pcx_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) ();

  logic                  valid;
  logic                  ready;
  logic [COORD_BITS:0]   pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic [BYTE_BITS-1:0]  color;
  logic                  run_last;

  modport source (output valid, output pixel_x, output pixel_y, output color,
                  output run_last, input ready);
  modport sink   (input valid, input pixel_x, input pixel_y, input color,
                  input run_last, output ready);

endinterface
`default_nettype wire

// ===== rtl/pcx_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCX decoder controller
// Two-state sequencer: take words, or hold the input while a run is written.
// ----------------------------------------------------------------------------
`include "pcx_rle_pixel_decoder_macros.svh"

module pcx_ctrl
  import pcx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire pcx_status_t status,
  output pcx_cmd_t         cmd
);

  typedef enum logic [1:0] {
    S_BYTE = 2'b01,
    S_RUN  = 2'b10
  } pcx_state_t;

  pcx_state_t state;
  pcx_state_t state_next;

  // Accept a word in S_BYTE whenever the output register has room
  assign in_ready = (state == S_BYTE) && status.out_free;

  // Decode the word and sequence run pixels
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_BYTE: begin
        if (in_valid && status.out_free) begin
          cmd.accept = 1'b1;
          if (status.awaiting) begin
            if (status.cnt_zero) begin
              cmd.drop_run = 1'b1;
            end else begin
              cmd.start_run = 1'b1;
              if (!status.cnt_one) begin
                state_next = S_RUN;
              end
            end
          end else if (status.header) begin
            cmd.load_hdr = 1'b1;
          end else begin
            cmd.emit_lit = 1'b1;
          end
        end
      end
      S_RUN: begin
        if (status.out_free) begin
          cmd.emit_run = 1'b1;
          if (status.rem_last) begin
            state_next = S_BYTE;
          end
        end
      end
      default: begin
        state_next = S_BYTE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_BYTE;
    end else begin
      state <= state_next;
    end
  end

  `PCX_ASSERT_IMP(a_no_accept_in_run, clk, rst, state == S_RUN, !cmd.accept)
  `PCX_ASSERT_IMP(a_accept_needs_room, clk, rst, cmd.accept, status.out_free)
  `PCX_ASSERT_NXT(a_run_ends, clk, rst, cmd.emit_run && status.rem_last, state == S_BYTE)
  `PCX_ASSERT_NXT(a_run_follows, clk, rst, cmd.start_run && !status.cnt_one, state == S_RUN)

endmodule
`default_nettype wire

// ===== rtl/pcx_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCX decoder datapath
// Run state, pixel position and the output register for pixel writes.
// ----------------------------------------------------------------------------
module pcx_dpath
  import pcx_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic [CFG_BITS-1:0]   start_x,
  input  wire logic [CFG_BITS-1:0]   start_y,
  input  wire logic [CFG_BITS-1:0]   line_bytes,
  input  wire logic [BYTE_BITS-1:0]  data_byte,
  input  wire logic                  frame_start,
  input  wire pcx_cmd_t              cmd,
  output pcx_status_t                status,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [COORD_BITS:0]        pixel_x,
  output logic [COORD_BITS-1:0]      pixel_y,
  output logic [BYTE_BITS-1:0]       color,
  output logic                       run_last
);

  localparam int XW = COORD_BITS + 1;
  localparam int LW = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;

  // Control state
  logic [COUNT_BITS-1:0] pending_count, pending_count_next;
  logic                  awaiting_color, awaiting_color_next;
  logic [COUNT_BITS-1:0] remaining, remaining_next;
  logic [COORD_BITS-1:0] column, column_next;
  logic [COORD_BITS-1:0] row, row_next;
  logic                  out_valid_next;

  // Run colour
  logic [BYTE_BITS-1:0]  run_color;

  // Position after an optional frame restart
  logic                  restart;
  logic [COORD_BITS-1:0] col_eff;
  logic [COORD_BITS-1:0] row_eff;
  logic [COORD_BITS-1:0] col_inc;
  logic                  wrap;
  logic                  emit;
  logic [BYTE_BITS-1:0]  emit_color;
  logic                  emit_last;

  assign restart = cmd.accept && frame_start;
  assign col_eff = restart ? '0 : column;
  assign row_eff = restart ? COORD_BITS'(start_y) : row;
  assign col_inc = col_eff + COORD_BITS'(1);
  assign wrap    = (LW'(col_inc) >= LW'(line_bytes)) || (col_inc == '0);

  // Report status
  always_comb begin
    status          = '0;
    status.out_free = !out_valid || out_ready;
    status.awaiting = awaiting_color && !frame_start;
    status.header   = (data_byte & RUN_MASK) == RUN_MASK;
    status.cnt_zero = pending_count == '0;
    status.cnt_one  = pending_count == COUNT_BITS'(1);
    status.rem_last = remaining == COUNT_BITS'(1);
  end

  // Select what is written
  assign emit       = cmd.emit_lit || cmd.start_run || cmd.emit_run;
  assign emit_color = cmd.emit_run ? run_color : data_byte;
  always_comb begin
    if (cmd.emit_run) begin
      emit_last = remaining == COUNT_BITS'(1);
    end else if (cmd.start_run) begin
      emit_last = pending_count == COUNT_BITS'(1);
    end else begin
      emit_last = 1'b1;
    end
  end

  // Next control state
  always_comb begin
    pending_count_next  = pending_count;
    awaiting_color_next = awaiting_color;
    remaining_next      = remaining;
    column_next         = column;
    row_next            = row;
    if (restart) begin
      pending_count_next  = '0;
      awaiting_color_next = 1'b0;
      column_next         = '0;
      row_next            = COORD_BITS'(start_y);
    end
    if (cmd.load_hdr) begin
      pending_count_next  = data_byte[COUNT_BITS-1:0];
      awaiting_color_next = 1'b1;
    end
    if (cmd.drop_run || cmd.start_run) begin
      pending_count_next  = '0;
      awaiting_color_next = 1'b0;
    end
    if (cmd.start_run) begin
      remaining_next = pending_count - COUNT_BITS'(1);
    end
    if (cmd.emit_run) begin
      remaining_next = remaining - COUNT_BITS'(1);
    end
    // Advance position, wrapping the line and saturating the row
    if (emit) begin
      if (wrap) begin
        column_next = '0;
        row_next    = (row_eff != '1) ? row_eff + COORD_BITS'(1) : row_eff;
      end else begin
        column_next = col_inc;
        row_next    = row_eff;
      end
    end
    // Hold the output word until taken
    if (emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count  <= '0;
      awaiting_color <= 1'b0;
      remaining      <= '0;
      column         <= '0;
      row            <= '0;
      out_valid      <= 1'b0;
    end else begin
      pending_count  <= pending_count_next;
      awaiting_color <= awaiting_color_next;
      remaining      <= remaining_next;
      column         <= column_next;
      row            <= row_next;
      out_valid      <= out_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.start_run) begin
      run_color <= data_byte;
    end
    if (emit) begin
      pixel_x  <= XW'(start_x) + XW'(col_eff);
      pixel_y  <= row_eff;
      color    <= emit_color;
      run_last <= emit_last;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/pcx_rle_pixel_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// PCX RLE pixel decoder
// Turns 8-bit single-plane PCX image bytes into pixel writes with coordinates.
// ----------------------------------------------------------------------------
// Rate: a literal byte is taken and its pixel written in the same cycle, so
// literals stream at one per cycle unless the sink stalls. A run header is
// taken and writes nothing. A run colour byte with count n writes n pixels: the
// first as the byte is taken, the other n - 1 one per cycle unless the sink
// stalls, while the controller holds the input; a zero count writes nothing.
// All pixels pass through a single output register, so a stalled pixel sink
// stalls the input as well. Configuration writes take effect on the next edge.
// ----------------------------------------------------------------------------
module pcx_rle_pixel_decoder
  import pcx_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_wr_en,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_data,
  pcx_byte_if.sink                     stream,
  pcx_pixel_if.source                  pixels
);

  logic [CFG_BITS-1:0] start_x;
  logic [CFG_BITS-1:0] start_y;
  logic [CFG_BITS-1:0] line_bytes;

  pcx_cmd_t    cmd;
  pcx_status_t status;

  // Configuration registers; unknown indexes drop the write
  always_ff @(posedge clk) begin
    if (rst) begin
      start_x    <= '0;
      start_y    <= '0;
      line_bytes <= LINE_BYTES_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_START_X:    start_x    <= cfg_data;
        REG_START_Y:    start_y    <= cfg_data;
        REG_LINE_BYTES: line_bytes <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Sequencer
  pcx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stream.valid),
    .in_ready (stream.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Datapath and output register
  pcx_dpath #(
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .start_x     (start_x),
    .start_y     (start_y),
    .line_bytes  (line_bytes),
    .data_byte   (stream.data_byte),
    .frame_start (stream.frame_start),
    .cmd         (cmd),
    .status      (status),
    .out_ready   (pixels.ready),
    .out_valid   (pixels.valid),
    .pixel_x     (pixels.pixel_x),
    .pixel_y     (pixels.pixel_y),
    .color       (pixels.color),
    .run_last    (pixels.run_last)
  );

endmodule
`default_nettype wire
